/* hw/rtl/capture_pair_frequency_meter_macros.svh */
// Assertion macros shared by the capture pair frequency meter RTL.
// Included by the top level; depends on nothing else.
`ifndef CAPTURE_PAIR_FREQUENCY_METER_MACROS_SVH
`define CAPTURE_PAIR_FREQUENCY_METER_MACROS_SVH

// Checked only while the block is out of reset.
`define CPFM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CPFM_ASSERT_RST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cpfm_pkg.sv */
// Package for the capture pair frequency meter: widths, register indexes,
// controller states and the command/status structs. Depends on nothing.
`timescale 1ns / 1ps

package cpfm_pkg;

    // Width of the free-running timer whose captures come in.
    localparam int COUNTER_WIDTH = 16;
    localparam int PERIOD_W      = COUNTER_WIDTH + 1;
    localparam int TICK_W        = 27;
    localparam int MOD_W         = 17;
    localparam int FREQ_W        = 36;
    // 2*rate in Q.8 is rate shifted left by nine.
    localparam int FRAC_SHIFT    = 9;
    localparam int DIV_STEPS     = FREQ_W;
    localparam int CNT_W         = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = TICK_W;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 56;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b1;

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(8000000);
    localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(65536);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic store_first;  // keep the capture as the first of a pair
        logic start;        // form the period and load the divider
        logic div_step;     // one quotient bit
        logic out_load;     // move the finished result to the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;     // output register empty or being taken now
    } t_status;

endpackage

/* hw/rtl/cpfm_ctrl.sv */
// Controller of the capture pair frequency meter: pairs captures, sequences
// the divider and hands results to the output. Uses cpfm_pkg.
`timescale 1ns / 1ps

module cpfm_ctrl
    import cpfm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic               r_have_first, n_have_first;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_have_first <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state      <= n_state;
            r_have_first <= n_have_first;
            r_cnt        <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_have_first = r_have_first;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_have_first) begin
                        o_cmd.start  = 1'b1;
                        n_have_first = 1'b0;
                        n_cnt        = '0;
                        n_state      = ST_DIV;
                    end else begin
                        o_cmd.store_first = 1'b1;
                        n_have_first      = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/cpfm_datapath.sv */
// Datapath of the capture pair frequency meter: configuration registers,
// period arithmetic, bit-serial restoring divider, output register. Uses cpfm_pkg.
`timescale 1ns / 1ps

module cpfm_datapath
    import cpfm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [COUNTER_WIDTH-1:0] i_capture,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [PERIOD_W-1:0]      o_period,
    output logic [FREQ_W-1:0]        o_freq
);

    logic [TICK_W-1:0]        r_tick;
    logic [MOD_W-1:0]         r_modulus;
    logic [COUNTER_WIDTH-1:0] r_first;
    logic [PERIOD_W-1:0]      r_div;
    logic [PERIOD_W-1:0]      r_rem, n_rem;
    logic [FREQ_W-1:0]        r_nq, n_nq;
    logic                     r_out_valid;
    logic [PERIOD_W-1:0]      r_out_period;
    logic [FREQ_W-1:0]        r_out_freq;

    logic [PERIOD_W-1:0]      diff;
    logic [COUNTER_WIDTH-1:0] back;
    logic [MOD_W-1:0]         back_ext;
    logic [PERIOD_W-1:0]      wrapped;
    logic [PERIOD_W-1:0]      period;
    logic [PERIOD_W:0]        trial;
    logic [PERIOD_W:0]        trial_sub;
    logic                     q_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= TICK_RESET;
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TICK_RATE: r_tick    <= i_cfg_data[TICK_W-1:0];
                REG_MODULUS:   r_modulus <= i_cfg_data[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Second capture not above the first means one counter wrap; a modulus
    // too small for the gap saturates the period at one tick.
    always_comb begin
        diff     = PERIOD_W'(i_capture) - PERIOD_W'(r_first);
        back     = r_first - i_capture;
        back_ext = MOD_W'(back);
        wrapped  = (r_modulus > back_ext) ? PERIOD_W'(r_modulus - back_ext)
                                          : PERIOD_W'(1);
        period   = (i_capture > r_first) ? diff : wrapped;
    end

    // Restoring division: numerator bits shift out the top of r_nq while
    // quotient bits shift in at the bottom.
    always_comb begin
        trial     = {r_rem, r_nq[FREQ_W-1]};
        trial_sub = trial - {1'b0, r_div};
        q_bit     = (trial >= {1'b0, r_div});
        n_rem     = q_bit ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        n_nq      = {r_nq[FREQ_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_first) begin
            r_first <= i_capture;
        end
        if (i_cmd.start) begin
            r_div <= period;
            r_rem <= '0;
            r_nq  <= FREQ_W'({r_tick, FRAC_SHIFT'(0)});
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
        if (i_cmd.out_load) begin
            r_out_period <= r_div;
            r_out_freq   <= r_nq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_period          = r_out_period;
    assign o_freq            = r_out_freq;

endmodule

/* hw/rtl/capture_pair_frequency_meter.sv */
// Top level of the capture pair frequency meter: controller plus datapath.
// Uses cpfm_pkg, cpfm_ctrl, cpfm_datapath and the assertion macro header.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+----------------------------------
//  s_axis   | in        | tvalid / tready       | tdata[15:0] capture_value
//  m_axis   | out       | tvalid / tready       | tdata[16:0] period, [52:17] freq
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (27 bits)
//
// A first capture is stored as the first of a pair. A second capture starts a
// one-bit-a-cycle divider of 36 steps, whose result then moves to the output register.
// Reset (synchronous, active low) clears the pairing and the output valid and
// restores the register defaults. A stalled output holds the controller until the
// register frees; no captures are taken while the controller waits.
`timescale 1ns / 1ps

`include "capture_pair_frequency_meter_macros.svh"

module capture_pair_frequency_meter
    import cpfm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] capture_value
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [16:0] period_ticks,
                                                     // [52:17] frequency_q8, zeros above
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd                cmd;
    t_status             status;
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;

    assign o_cfg_ready = 1'b1;

    cpfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cpfm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_capture   (i_s_axis_tdata[COUNTER_WIDTH-1:0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_period    (period),
        .o_freq      (freq)
    );

    assign o_m_axis_tdata = {(OUT_TDATA_W - FREQ_W - PERIOD_W)'(0), freq, period};

    `CPFM_ASSERT(a_load_only_when_free, i_clk, i_rst_n, cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready), "result loaded over an untaken item")
    `CPFM_ASSERT(a_valid_from_load, i_clk, i_rst_n, $rose(o_m_axis_tvalid) |-> $past(cmd.out_load), "output valid rose without a load")
    `CPFM_ASSERT(a_period_nonzero, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[PERIOD_W-1:0] != '0), "zero period on output")
    `CPFM_ASSERT_RST(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule
